// File: design/lpfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam int unsigned HDR_BYTES = 8;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned SHIFT_W   = 56;

  localparam logic [31:0] MAX_BODY_LIMIT = 32'd4294967287;
  localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(HDR_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HDR_BYTES - 1);

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] ERR_TYPE_ZERO = 2'd0;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
  localparam logic [1:0] ERR_FAILED    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] msg_type;
    logic [31:0] body_length;
    logic [7:0]  body_byte;
    logic        last;
    logic [1:0]  error_code;
  } result_t;

  typedef struct packed {
    logic             failed;
    logic [CNT_W-1:0] header_count;
    logic             body_pending;
  } status_t;

endpackage

// File: design/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Byte-stream deframer for frames with a 32-bit big-endian type and length.
// ----------------------------------------------------------------------------
// The parser takes one byte per beat and accepts a new beat every cycle as
// long as the result register is free or being emptied; each beat is decoded
// combinationally by the header counter, length compare and body down counter,
// and its result (if any) is registered and appears on the output in the cycle
// after acceptance. A clear beat resets the parser state and produces no result.
module length_prefixed_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_msg_type,
  output logic [31:0] out_body_length,
  output logic [7:0]  out_body_byte,
  output logic        out_last,
  output logic [1:0]  out_error_code,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic              accept;
  logic              res_valid;
  logic              busy;
  logic [31:0]       max_body_r;
  lpfp_pkg::result_t res;
  lpfp_pkg::result_t out_res;
  lpfp_pkg::status_t status;

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= lpfp_pkg::MAX_BODY_RESET;
    end else if (cfg_wr_en) begin
      max_body_r <= (cfg_wr_data > lpfp_pkg::MAX_BODY_LIMIT) ?
                    lpfp_pkg::MAX_BODY_LIMIT : cfg_wr_data;
    end
  end

  lpfp_core u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .opcode         (in_opcode),
    .data_byte      (in_data_byte),
    .max_body_bytes (max_body_r),
    .res_valid      (res_valid),
    .res            (res),
    .status         (status)
  );

  lpfp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy      (busy),
    .out_res   (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_msg_type    = out_res.msg_type;
  assign out_body_length = out_res.body_length;
  assign out_body_byte   = out_res.body_byte;
  assign out_last        = out_res.last;
  assign out_error_code  = out_res.error_code;

  // A sticky failure is only ever raised once a full header has arrived.
  a_failed_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    status.failed |-> status.header_count == lpfp_pkg::CNT_FULL)
    else $error("failure flag set outside a completed header");

  // Inside a healthy body there is always at least one byte still owed.
  a_body_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (status.header_count == lpfp_pkg::CNT_FULL && !status.failed)
      |-> status.body_pending)
    else $error("body phase entered with nothing left to receive");

  // A data beat taken while failed must come out as an already-failed error.
  a_failed_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == lpfp_pkg::OP_DATA && status.failed)
      |=> (out_valid && out_kind == lpfp_pkg::KIND_ERROR &&
           out_error_code == lpfp_pkg::ERR_FAILED))
    else $error("beat while failed did not yield a failure result");

  // A clear beat never produces a result.
  a_clear_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == lpfp_pkg::OP_CLEAR) |-> !res_valid)
    else $error("clear beat produced a result");

endmodule

// File: design/lpfp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_core
// Parser state and the single-pass decode of one beat into at most one result.
// ----------------------------------------------------------------------------
module lpfp_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic                    opcode,
  input  logic [7:0]              data_byte,
  input  logic [31:0]             max_body_bytes,
  output logic                    res_valid,
  output lpfp_pkg::result_t       res,
  output lpfp_pkg::status_t       status
);

  logic [lpfp_pkg::SHIFT_W-1:0] header_shift_r, header_shift_nxt;
  logic [lpfp_pkg::CNT_W-1:0]   header_count_r, header_count_nxt;
  logic [31:0]                  body_remaining_r, body_remaining_nxt;
  logic [31:0]                  frame_type_r, frame_type_nxt;
  logic [31:0]                  frame_length_r, frame_length_nxt;
  logic                         failed_r, failed_nxt;
  logic [63:0]                  hdr;

  assign hdr = {header_shift_r, data_byte};

  always_comb begin
    header_shift_nxt   = header_shift_r;
    header_count_nxt   = header_count_r;
    body_remaining_nxt = body_remaining_r;
    frame_type_nxt     = frame_type_r;
    frame_length_nxt   = frame_length_r;
    failed_nxt         = failed_r;
    res_valid          = 1'b0;
    res.kind           = lpfp_pkg::KIND_HEADER;
    res.msg_type       = frame_type_r;
    res.body_length    = frame_length_r;
    res.body_byte      = 8'd0;
    res.last           = 1'b0;
    res.error_code     = lpfp_pkg::ERR_TYPE_ZERO;
    if (accept) begin
      if (opcode == lpfp_pkg::OP_CLEAR) begin
        header_shift_nxt   = '0;
        header_count_nxt   = '0;
        body_remaining_nxt = '0;
        frame_type_nxt     = '0;
        frame_length_nxt   = '0;
        failed_nxt         = 1'b0;
      end else if (failed_r) begin
        res_valid      = 1'b1;
        res.kind       = lpfp_pkg::KIND_ERROR;
        res.error_code = lpfp_pkg::ERR_FAILED;
      end else if (header_count_r != lpfp_pkg::CNT_FULL) begin
        header_count_nxt = header_count_r + 1'b1;
        if (header_count_r != lpfp_pkg::CNT_LAST) begin
          header_shift_nxt = hdr[lpfp_pkg::SHIFT_W-1:0];
        end else begin
          frame_type_nxt   = hdr[63:32];
          frame_length_nxt = hdr[31:0];
          res_valid        = 1'b1;
          res.msg_type     = hdr[63:32];
          res.body_length  = hdr[31:0];
          if (hdr[63:32] == 32'd0) begin
            failed_nxt     = 1'b1;
            res.kind       = lpfp_pkg::KIND_ERROR;
            res.error_code = lpfp_pkg::ERR_TYPE_ZERO;
          end else if (hdr[31:0] > max_body_bytes) begin
            failed_nxt     = 1'b1;
            res.kind       = lpfp_pkg::KIND_ERROR;
            res.error_code = lpfp_pkg::ERR_TOO_LARGE;
          end else begin
            body_remaining_nxt = hdr[31:0];
            res.kind           = lpfp_pkg::KIND_HEADER;
            if (hdr[31:0] == 32'd0) begin
              res.last         = 1'b1;
              header_count_nxt = '0;
              header_shift_nxt = '0;
            end
          end
        end
      end else begin
        res_valid     = 1'b1;
        res.kind      = lpfp_pkg::KIND_BODY;
        res.body_byte = data_byte;
        if (body_remaining_r <= 32'd1) begin
          res.last           = 1'b1;
          body_remaining_nxt = '0;
          header_count_nxt   = '0;
          header_shift_nxt   = '0;
        end else begin
          body_remaining_nxt = body_remaining_r - 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_shift_r   <= '0;
      header_count_r   <= '0;
      body_remaining_r <= '0;
      frame_type_r     <= '0;
      frame_length_r   <= '0;
      failed_r         <= 1'b0;
    end else begin
      header_shift_r   <= header_shift_nxt;
      header_count_r   <= header_count_nxt;
      body_remaining_r <= body_remaining_nxt;
      frame_type_r     <= frame_type_nxt;
      frame_length_r   <= frame_length_nxt;
      failed_r         <= failed_nxt;
    end
  end

  assign status.failed       = failed_r;
  assign status.header_count = header_count_r;
  assign status.body_pending = (body_remaining_r != 32'd0);

endmodule

// File: design/lpfp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_out_reg
// Result register that holds one beat for the downstream side.
// ----------------------------------------------------------------------------
module lpfp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lpfp_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              busy,
  output lpfp_pkg::result_t out_res
);

  logic              valid_r, valid_nxt;
  lpfp_pkg::result_t res_r;

  assign busy = valid_r & out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the length-prefixed frame parser.
// A scoreboard class tracks the header, body and failure state of the parser
// and predicts the result of every accepted beat. Results are compared field
// by field in order. Frames are mostly well formed with random types,
// lengths and bodies, mixed with cut frames, stray bytes and clears. The
// maximum body size is changed between phases, and both channels stall in
// random bursts.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WATCHDOG_CYCLES = 1000;
  localparam int unsigned PHASE_BEATS     = 155;
  localparam logic [1:0]  NO_CODE         = 2'd0;

  class frame_scoreboard;
    logic [31:0] max_body;
    logic [63:0] hdr_shift;
    int unsigned hdr_count;
    logic [31:0] body_left;
    logic [31:0] cur_type;
    logic [31:0] cur_len;
    bit          failed;
    lpfp_pkg::result_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      max_body   = lpfp_pkg::MAX_BODY_RESET;
      mismatches = 0;
      checked    = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      hdr_shift = '0;
      hdr_count = 0;
      body_left = '0;
      cur_type  = '0;
      cur_len   = '0;
      failed    = 1'b0;
    endfunction

    function void set_max_body(logic [31:0] value);
      max_body = (value > lpfp_pkg::MAX_BODY_LIMIT) ? lpfp_pkg::MAX_BODY_LIMIT : value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void queue_result(logic [1:0] kind, logic [7:0] data, logic fin,
                               logic [1:0] code);
      lpfp_pkg::result_t r;
      r.kind        = kind;
      r.msg_type    = cur_type;
      r.body_length = cur_len;
      r.body_byte   = data;
      r.last        = fin;
      r.error_code  = code;
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void note_beat(logic op, logic [7:0] data);
      logic fin;
      if (op == lpfp_pkg::OP_CLEAR) begin
        clear_parser();
        return;
      end
      if (failed) begin
        queue_result(lpfp_pkg::KIND_ERROR, 8'h00, 1'b0, lpfp_pkg::ERR_FAILED);
        return;
      end
      if (hdr_count < lpfp_pkg::HDR_BYTES) begin
        hdr_shift = {hdr_shift[55:0], data};
        hdr_count++;
        if (hdr_count < lpfp_pkg::HDR_BYTES) return;
        cur_type = hdr_shift[63:32];
        cur_len  = hdr_shift[31:0];
        if (cur_type == '0) begin
          failed = 1'b1;
          queue_result(lpfp_pkg::KIND_ERROR, 8'h00, 1'b0, lpfp_pkg::ERR_TYPE_ZERO);
          return;
        end
        if (cur_len > max_body) begin
          failed = 1'b1;
          queue_result(lpfp_pkg::KIND_ERROR, 8'h00, 1'b0, lpfp_pkg::ERR_TOO_LARGE);
          return;
        end
        body_left = cur_len;
        queue_result(lpfp_pkg::KIND_HEADER, 8'h00, cur_len == '0, NO_CODE);
        if (cur_len == '0) begin
          hdr_count = 0;
          hdr_shift = '0;
        end
        return;
      end
      fin = (body_left <= 32'd1);
      queue_result(lpfp_pkg::KIND_BODY, data, fin, NO_CODE);
      if (body_left > 0) body_left--;
      if (fin) begin
        body_left = '0;
        hdr_count = 0;
        hdr_shift = '0;
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: result %0d: %s", $realtime, checked, msg);
      mismatches++;
    endtask

    task check_result(lpfp_pkg::result_t got);
      lpfp_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", got.kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.msg_type !== want.msg_type)
        report($sformatf("msg_type %08h, want %08h", got.msg_type, want.msg_type));
      if (got.body_length !== want.body_length)
        report($sformatf("body_length %08h, want %08h", got.body_length,
                         want.body_length));
      if (got.body_byte !== want.body_byte)
        report($sformatf("body_byte %02h, want %02h", got.body_byte, want.body_byte));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
      if (got.error_code !== want.error_code)
        report($sformatf("error_code %0d, want %0d", got.error_code, want.error_code));
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_opcode = lpfp_pkg::OP_DATA;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_kind;
  logic [31:0] out_msg_type;
  logic [31:0] out_body_length;
  logic [7:0]  out_body_byte;
  logic        out_last;
  logic [1:0]  out_error_code;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'h0;

  frame_scoreboard sb;
  bit              idle_on = 1'b1;
  bit              tail_quiet = 1'b0;
  int unsigned     beats_sent = 0;
  int unsigned     quiet_cycles = 0;

  length_prefixed_frame_parser dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_msg_type    (out_msg_type),
    .out_body_length (out_body_length),
    .out_body_byte   (out_body_byte),
    .out_last        (out_last),
    .out_error_code  (out_error_code),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always begin
    @(posedge clk);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // Handshake signals are stable between the driving edge and the next
  // accepting edge, so both channels are observed at the falling edge.
  always @(negedge clk) begin
    lpfp_pkg::result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.kind        = out_kind;
        got.msg_type    = out_msg_type;
        got.body_length = out_body_length;
        got.body_byte   = out_body_byte;
        got.last        = out_last;
        got.error_code  = out_error_code;
        sb.check_result(got);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_CYCLES);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] data);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= data;
    do @(negedge clk); while (in_stall);
    sb.note_beat(op, data);
    beats_sent++;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_body(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_max_body(value);
  endtask

  task automatic send_frame_bytes(input logic [31:0] ftype, input logic [31:0] flen,
                                  input int unsigned nbody);
    logic [63:0] hdr;
    hdr = {ftype, flen};
    for (int k = 0; k < 8; k++) send_beat(lpfp_pkg::OP_DATA, hdr[63 - 8 * k -: 8]);
    for (int unsigned k = 0; k < nbody; k++) send_beat(lpfp_pkg::OP_DATA, 8'($urandom));
  endtask

  task automatic send_frame();
    logic [31:0] ftype;
    logic [31:0] flen;
    logic [63:0] hdr;
    int unsigned nbody;
    ftype = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom;
    case ($urandom_range(0, 9))
      6:       flen = sb.max_body;
      7:       flen = (sb.max_body < lpfp_pkg::MAX_BODY_LIMIT) ? sb.max_body + 1 : sb.max_body;
      8:       flen = $urandom;
      9:       flen = $urandom_range(7, 40);
      default: flen = $urandom_range(0, 6);
    endcase
    if ($urandom_range(0, 24) == 0) begin
      hdr = {ftype, flen};
      for (int k = 0; k < $urandom_range(1, 7); k++)
        send_beat(lpfp_pkg::OP_DATA, hdr[63 - 8 * k -: 8]);
      send_beat(lpfp_pkg::OP_CLEAR, 8'($urandom));
      return;
    end
    if (ftype == '0 || flen > sb.max_body) begin
      send_frame_bytes(ftype, flen, 0);
      repeat ($urandom_range(0, 3)) send_beat(lpfp_pkg::OP_DATA, 8'($urandom));
      send_beat(lpfp_pkg::OP_CLEAR, 8'($urandom));
      return;
    end
    if (flen > 64) nbody = $urandom_range(1, 8);
    else if (flen >= 2 && $urandom_range(0, 14) == 0) nbody = $urandom_range(1, flen - 1);
    else nbody = flen;
    send_frame_bytes(ftype, flen, nbody);
    if (nbody < flen) send_beat(lpfp_pkg::OP_CLEAR, 8'($urandom));
  endtask

  task automatic run_frames(input int unsigned beats);
    int unsigned stop_at;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      if (!tail_quiet && $urandom_range(0, 39) == 0) idle_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 11))
        0: send_beat(lpfp_pkg::OP_CLEAR, 8'($urandom));
        1: begin
          repeat ($urandom_range(1, 3)) send_beat(lpfp_pkg::OP_DATA, 8'($urandom));
          send_beat(lpfp_pkg::OP_CLEAR, 8'($urandom));
        end
        default: send_frame();
      endcase
    end
  endtask

  initial begin
    logic [31:0] settings[6];
    sb = new();
    settings[0] = 32'd0;
    settings[1] = 32'd5;
    settings[2] = 32'hFFFF_FFFF;
    settings[3] = lpfp_pkg::MAX_BODY_LIMIT - 1;
    settings[4] = $urandom_range(7, 300);
    settings[5] = lpfp_pkg::MAX_BODY_RESET;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty body, type zero, a byte while failed, clear, one-byte body.
    send_frame_bytes(32'hFFFF_FFFF, 32'd0, 0);
    send_frame_bytes(32'd0, 32'd3, 0);
    send_beat(lpfp_pkg::OP_DATA, 8'hA5);
    send_beat(lpfp_pkg::OP_CLEAR, 8'hFF);
    send_frame_bytes(32'h0000_0001, 32'd1, 1);
    wait_idle();

    run_frames(PHASE_BEATS);
    wait_idle();
    foreach (settings[i]) begin
      write_max_body(settings[i]);
      if (i == 5) begin
        idle_on    = 1'b0;
        tail_quiet = 1'b1;
      end
      run_frames(PHASE_BEATS);
      wait_idle();
    end

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
